FILE: src/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, character codes and lookup functions of the base64url decoder.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Offsets that bring each character range to its sextet value.
    localparam logic [7:0] LOWER_OFFSET = 8'd71;   // 'a' - 26
    localparam logic [7:0] DIGIT_OFFSET = 8'd252;  // '0' - 52, modulo 256

    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    typedef enum logic [1:0] {
        ST_DATA       = 2'd0,
        ST_INVALID    = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_END_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [17:0] bit_accumulator;
        logic [1:0]  group_position;
        logic [2:0]  data_char_count;
        logic        padding_seen;
        logic        discarding;
    } group_state_t;

    // One run of results caused by a single request, first byte at index 0.
    typedef struct packed {
        logic [1:0]       count;
        logic [0:2][7:0]  bytes;
        status_t          status;
        logic             eom;
    } run_t;

    // Bit 6 set marks a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] diff;
        logic [6:0] res;
        diff = 8'd0;
        res  = 7'h40;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]:
            begin
                diff = c - CHAR_UPPER_A;
                res  = {1'b0, diff[5:0]};
            end
            [CHAR_LOWER_A:CHAR_LOWER_Z]:
            begin
                diff = c - LOWER_OFFSET;
                res  = {1'b0, diff[5:0]};
            end
            [CHAR_DIGIT_0:CHAR_DIGIT_9]:
            begin
                diff = c - DIGIT_OFFSET;
                res  = {1'b0, diff[5:0]};
            end
            CHAR_MINUS, CHAR_PLUS:
            begin
                res = {1'b0, SEXTET_62};
            end
            CHAR_UNDER, CHAR_SLASH:
            begin
                res = {1'b0, SEXTET_63};
            end
            default:
            begin
                res = 7'h40;
            end
        endcase
        return res;
    endfunction

    // Left-aligns the collected sextets of a partial group in 24 bits.
    function automatic logic [23:0] place_group(input logic [17:0] acc,
                                                input logic [2:0] n);
        logic [23:0] res;
        case (n)
            3'd1:    res = {acc[5:0], 18'd0};
            3'd2:    res = {acc[11:0], 12'd0};
            3'd3:    res = {acc, 6'd0};
            default: res = 24'd0;
        endcase
        return res;
    endfunction

endpackage

FILE: src/b64_decode.sv
// ----------------------------------------------------------------------------
// b64_decode
// Combinational step: one character against the group state gives the next
// state and the run of results it causes.
// ----------------------------------------------------------------------------
module b64_decode
(
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    input  b64_pkg::group_state_t state_cur,
    output b64_pkg::group_state_t state_next,
    output b64_pkg::run_t         run
);

    logic [6:0]       sextet;
    logic [2:0]       n;
    logic [23:0]      v24;
    logic [17:0]      acc_new;
    logic             complete;
    logic             fail;
    b64_pkg::status_t fail_code;

    assign sextet = b64_pkg::sextet_of(char_code);

    always_comb
    begin
        state_next = state_cur;
        run        = '0;
        run.status = b64_pkg::ST_DATA;
        n          = 3'd0;
        v24        = 24'd0;
        acc_new    = state_cur.bit_accumulator;
        complete   = (state_cur.group_position == 2'd3);
        fail       = 1'b0;
        fail_code  = b64_pkg::ST_DATA;

        if (state_cur.discarding)
        begin
            // Silently drop everything up to the end of the message.
            if (last_char)
            begin
                state_next = '0;
            end
        end
        else
        begin
            if (char_code == b64_pkg::CHAR_PAD)
            begin
                if (!state_cur.group_position[1])
                begin
                    fail      = 1'b1;
                    fail_code = b64_pkg::ST_BAD_LENGTH;
                end
                else
                begin
                    state_next.padding_seen = 1'b1;
                    n   = state_cur.data_char_count;
                    v24 = b64_pkg::place_group(state_cur.bit_accumulator, n);
                end
            end
            else if (sextet[6])
            begin
                fail      = 1'b1;
                fail_code = b64_pkg::ST_INVALID;
            end
            else if (state_cur.padding_seen)
            begin
                fail      = 1'b1;
                fail_code = b64_pkg::ST_BAD_LENGTH;
            end
            else
            begin
                if (state_cur.data_char_count >= 3'd3)
                begin
                    n   = 3'd4;
                    v24 = {state_cur.bit_accumulator, sextet[5:0]};
                end
                else
                begin
                    n       = state_cur.data_char_count + 3'd1;
                    acc_new = {state_cur.bit_accumulator[11:0], sextet[5:0]};
                    state_next.bit_accumulator = acc_new;
                    v24 = b64_pkg::place_group(acc_new, n);
                end
                state_next.data_char_count = n;
            end

            if (!fail)
            begin
                state_next.group_position = state_cur.group_position + 2'd1;
                if (complete || last_char)
                begin
                    if (n == 3'd1)
                    begin
                        fail      = 1'b1;
                        fail_code = b64_pkg::ST_BAD_LENGTH;
                    end
                    else
                    begin
                        state_next = '0;
                        run.bytes  = {v24[23:16], v24[15:8], v24[7:0]};
                        run.eom    = last_char;
                        case (n)
                            3'd2:    run.count = 2'd1;
                            3'd3:    run.count = 2'd2;
                            3'd4:    run.count = 2'd3;
                            default:
                            begin
                                // A group closed with nothing to emit.
                                run.count  = last_char ? 2'd1 : 2'd0;
                                run.status = b64_pkg::ST_END_EMPTY;
                                run.bytes  = '0;
                            end
                        endcase
                    end
                end
            end

            if (fail)
            begin
                state_next            = '0;
                state_next.discarding = !last_char;
                run.count             = 2'd1;
                run.bytes             = '0;
                run.status            = fail_code;
                run.eom               = 1'b1;
            end
        end
    end

endmodule

FILE: src/b64_out_buf.sv
// ----------------------------------------------------------------------------
// b64_out_buf
// Result register that holds one run and hands its results out in order.
// ----------------------------------------------------------------------------
module b64_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  b64_pkg::run_t     run_in,
    output logic              free,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [7:0]        data_byte,
    output logic [1:0]        status,
    output logic              end_of_message,
    output logic              last_of_run
);

    b64_pkg::run_t run_reg;
    b64_pkg::run_t run_next;
    logic [1:0]    left_reg;
    logic [1:0]    left_next;
    logic [1:0]    idx;
    logic          fire;

    assign result_valid   = (left_reg != 2'd0);
    assign fire           = result_valid && result_ready;
    // The run register can take a new run once its final result leaves.
    assign free           = (left_reg == 2'd0) || ((left_reg == 2'd1) && result_ready);
    assign idx            = run_reg.count - left_reg;
    assign last_of_run    = (left_reg == 2'd1);
    assign end_of_message = last_of_run && run_reg.eom;
    assign status         = run_reg.status;

    always_comb
    begin
        case (idx)
            2'd0:    data_byte = run_reg.bytes[0];
            2'd1:    data_byte = run_reg.bytes[1];
            2'd2:    data_byte = run_reg.bytes[2];
            default: data_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        left_next = left_reg;
        if (load)
        begin
            run_next  = run_in;
            left_next = run_in.count;
        end
        else if (fire)
        begin
            left_next = left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

FILE: src/base64url_decoder.sv
// A request is held in the input register, and its run is then loaded into the result register.
// Throughput: one character per cycle; a request that causes results waits in the
// input register while the previous run still has more than one result to hand out
// or its final result is not taken.
// Reset (rst_n, asynchronous, active low) empties the input and result registers
// and clears the group state and the discard flag at once.
// ----------------------------------------------------------------------------
// base64url_decoder
// Streaming base64url decoder that also accepts '+' and '/': one character per
// request in, decoded bytes and status reports out.
// ----------------------------------------------------------------------------
module base64url_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] data_byte,
    output logic [1:0] status,
    output logic       end_of_message,
    output logic       last_of_run
);

    // Input register. A character waits here until its run has a place in
    // the result register; characters that cause no result pass straight on.
    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Group state: accumulator, position, data count, padding and discard.
    b64_pkg::group_state_t state_reg;
    b64_pkg::group_state_t state_next;
    b64_pkg::group_state_t state_dec;

    b64_pkg::run_t run;
    logic          free;
    logic          advance;
    logic          load;
    logic          accept;

    b64_decode u_decode
    (
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .state_cur  (state_reg),
        .state_next (state_dec),
        .run        (run)
    );

    // A held character is decoded when it causes no result or when the
    // result register is ready for its run.
    assign advance    = in_full_reg && (free || (run.count == 2'd0));
    assign load       = advance && (run.count != 2'd0);
    assign char_ready = !in_full_reg || advance;
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = state_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= char_code;
            in_last_reg <= last_char;
        end
    end

    b64_out_buf u_out_buf
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .run_in         (run),
        .free           (free),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .data_byte      (data_byte),
        .status         (status),
        .end_of_message (end_of_message),
        .last_of_run    (last_of_run)
    );

endmodule

FILE: src/b64_checker.sv
// ----------------------------------------------------------------------------
// b64_checker
// Port-level checks of the base64url decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_ready,
    input logic [7:0] char_code,
    input logic       last_char,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] data_byte,
    input logic [1:0] status,
    input logic       end_of_message,
    input logic       last_of_run
);

    // A waiting character request keeps its contents.
    a_request_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=>
            char_valid && $stable(char_code) && $stable(last_char))
        else $error("waiting request changed");

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(data_byte) && $stable(status)
            && $stable(end_of_message) && $stable(last_of_run))
        else $error("stalled result changed");

    // The end of a message always closes a run.
    a_eom_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_message |-> last_of_run)
        else $error("end_of_message without last_of_run");

    // Every report other than data is a single result that ends the message.
    a_report_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != b64_pkg::ST_DATA) |->
            end_of_message && last_of_run && (data_byte == 8'd0))
        else $error("status report is not a lone final result");

    // A run that is not finished continues in the next result.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_of_run |=>
            result_valid && (status == b64_pkg::ST_DATA))
        else $error("run broken off");

endmodule

bind base64url_decoder b64_checker u_b64_checker (.*);
